### hw/rtl/sev_pkg.sv
// ----------------------------------------------------------------------------
// sev_pkg
// Types and constants shared by the sprite evaluation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sev_pkg;

   localparam int SPRITES_DEF = 64;
   localparam int SLOTS_DEF   = 8;

   localparam int IDX_W       = 6;
   localparam int CNT_W       = 4;
   localparam int PRI_ROWS    = 64;
   localparam int SEC_DEPTH   = 32;
   localparam int SEC_ADDR_W  = 5;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_TALL_ADDR = 3'd0;

   localparam logic [8:0] DOT_CLEAR_FIRST = 9'd1;
   localparam logic [8:0] DOT_CLEAR_LAST  = 9'd64;
   localparam logic [8:0] DOT_EVAL_FIRST  = 9'd65;
   localparam logic [8:0] DOT_EVAL_LAST   = 9'd256;
   localparam logic [7:0] SEC_FILL        = 8'hFF;

   typedef enum logic [1:0] {
      PH_NONE     = 2'd0,
      PH_COPY     = 2'd1,
      PH_OVERFLOW = 2'd2,
      PH_IDLE     = 2'd3
   } phase_type;

   typedef struct packed {
      logic [1:0] op;
      logic [8:0] dot;
      logic [8:0] line;
      logic [7:0] table_addr;
      logic [7:0] write_data;
   } req_item_type;

   typedef struct packed {
      logic             overflow_pulse;
      logic             zero_in_range;
      logic [CNT_W-1:0] found_count;
      logic             clear_reads;
      logic [7:0]       read_data;
   } rsp_item_type;

   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic [7:0] data;
   } pri_wr_type;

endpackage

### hw/rtl/sev_req_if.sv
// ----------------------------------------------------------------------------
// sev_req_if
// Request channel: valid/ready handshake with the tick or table access.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sev_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [8:0] dot;
   logic [8:0] line;
   logic [7:0] table_addr;
   logic [7:0] write_data;

   modport source (output valid, output op, output dot, output line,
                   output table_addr, output write_data, input ready);
   modport sink   (input valid, input op, input dot, input line,
                   input table_addr, input write_data, output ready);
endinterface

### hw/rtl/sev_rsp_if.sv
// ----------------------------------------------------------------------------
// sev_rsp_if
// Response channel: valid/ready handshake with the evaluation status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sev_rsp_if;
   logic       valid;
   logic       ready;
   logic       overflow_pulse;
   logic       zero_in_range;
   logic [3:0] found_count;
   logic       clear_reads;
   logic [7:0] read_data;

   modport source (output valid, output overflow_pulse, output zero_in_range,
                   output found_count, output clear_reads, output read_data,
                   input ready);
   modport sink   (input valid, input overflow_pulse, input zero_in_range,
                   input found_count, input clear_reads, input read_data,
                   output ready);
endinterface

### hw/rtl/sprite_evaluation_secondary_copy_top.sv
// ----------------------------------------------------------------------------
// sprite_evaluation_secondary_copy_top
// A request passes the input register, execute and the response register.
// Throughput: one request per cycle unless the response side stalls, set by the
// single execute pass and the one-row primary read issued ahead of each pass.
// Reset: synchronous; state, secondary table and primary-table valid bits
// clear at once, no clearing pass, requests are taken from the first cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_evaluation_secondary_copy_top #(
   parameter int SPRITES = sev_pkg::SPRITES_DEF,
   parameter int SLOTS   = sev_pkg::SLOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   sev_req_if.sink                           req_chan,
   sev_rsp_if.source                         rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sev_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [sev_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [sev_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import sev_pkg::*;

   req_item_type    in_ff;
   logic            in_valid_ff, in_valid_in;
   rsp_item_type    rsp_ff, result;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            tall_ff;
   logic            fire;
   logic            take;
   pri_wr_type      wr;
   logic [IDX_W-1:0] rd_row;
   logic [31:0]     rd_q, rd0_q;

   assign fire = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || fire;
   assign take = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tall_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (psel && penable && pwrite && paddr == CSR_TALL_ADDR) begin
            tall_ff <= pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_ff.op         <= req_chan.op;
         in_ff.dot        <= req_chan.dot;
         in_ff.line       <= req_chan.line;
         in_ff.table_addr <= req_chan.table_addr;
         in_ff.write_data <= req_chan.write_data;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_TALL_ADDR) ? {{(CSR_DATA_W-1){1'b0}}, tall_ff}
                                            : '0;

   sev_eval #(
      .SPRITES (SPRITES),
      .SLOTS   (SLOTS)
   ) u_eval (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_ff),
      .tall   (tall_ff),
      .result (result),
      .wr     (wr),
      .rd_row (rd_row),
      .rd_q   (rd_q),
      .rd0_q  (rd0_q)
   );

   sev_primary_mem u_primary (
      .clock  (clock),
      .wr     (wr),
      .rd_row (rd_row),
      .rd_q   (rd_q),
      .rd0_q  (rd0_q)
   );

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.overflow_pulse = rsp_ff.overflow_pulse;
   assign rsp_chan.zero_in_range  = rsp_ff.zero_in_range;
   assign rsp_chan.found_count    = rsp_ff.found_count;
   assign rsp_chan.clear_reads    = rsp_ff.clear_reads;
   assign rsp_chan.read_data      = rsp_ff.read_data;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.found_count <= CNT_W'(SLOTS))
      else $error("found count beyond slot count");

   a_pulse_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.overflow_pulse |-> rsp_ff.found_count == CNT_W'(SLOTS))
      else $error("overflow pulse before slots are full");

   a_fire_lands: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("executed request lost before response register");
`endif

endmodule

### hw/rtl/sev_primary_mem.sv
// ----------------------------------------------------------------------------
// sev_primary_mem
// Primary sprite table: 64 rows of four byte lanes, byte write, two
// registered row reads (one addressed, one fixed on row zero).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sev_primary_mem (
   input  logic                         clock,
   input  sev_pkg::pri_wr_type          wr,
   input  logic [sev_pkg::IDX_W-1:0]    rd_row,
   output logic [31:0]                  rd_q,
   output logic [31:0]                  rd0_q
);
   import sev_pkg::*;

   logic [31:0] mem [PRI_ROWS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[7:2]][{wr.addr[1:0], 3'b000} +: 8] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_q  <= mem[rd_row];
      rd0_q <= mem[0];
   end

endmodule

### hw/rtl/sev_eval.sv
// ----------------------------------------------------------------------------
// sev_eval
// Evaluation state, secondary table and the per-request execute logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sev_eval #(
   parameter int SPRITES = sev_pkg::SPRITES_DEF,
   parameter int SLOTS   = sev_pkg::SLOTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  sev_pkg::req_item_type      item,
   input  logic                       tall,
   output sev_pkg::rsp_item_type      result,
   output sev_pkg::pri_wr_type        wr,
   output logic [sev_pkg::IDX_W-1:0]  rd_row,
   input  logic [31:0]                rd_q,
   input  logic [31:0]                rd0_q
);
   import sev_pkg::*;

   logic [7:0]       sec_ff   [SEC_DEPTH];
   logic [7:0]       sec_in   [SEC_DEPTH];
   logic [7:0]       latch_ff [4];
   logic [7:0]       latch_in [4];
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [1:0]       off_ff, off_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   phase_type        phase_ff, phase_in;
   logic             zero_ff, zero_in;
   logic             clear_ff, clear_in;
   logic [255:0]     valid_ff;
   pri_wr_type       wr_last_ff;
   logic [7:0]       row_cur [4];
   logic [7:0]       row_zero [4];

   function automatic logic hit(input logic [8:0] line, input logic [7:0] top,
                                input logic is_tall);
      logic [9:0] bottom;
      bottom = {2'b00, top} + (is_tall ? 10'd16 : 10'd8);
      return ({1'b0, line} >= {2'b00, top}) && ({1'b0, line} < bottom);
   endfunction

   function automatic logic [IDX_W:0] idx_step(input logic [IDX_W-1:0] idx);
      logic [IDX_W:0] nxt;
      nxt = {1'b0, idx} + {{IDX_W{1'b0}}, 1'b1};
      if (nxt >= (IDX_W + 1)'(SPRITES)) begin
         return {1'b1, {IDX_W{1'b0}}};
      end
      return {1'b0, nxt[IDX_W-1:0]};
   endfunction

   // rows as they stand now: registered read plus last-edge write, gated by valid
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         row_cur[k] = rd_q[8*k +: 8];
         if (wr_last_ff.en && wr_last_ff.addr[7:2] == idx_ff &&
             wr_last_ff.addr[1:0] == 2'(k)) begin
            row_cur[k] = wr_last_ff.data;
         end
         if (!valid_ff[{idx_ff, 2'(k)}]) begin
            row_cur[k] = 8'h00;
         end
         row_zero[k] = rd0_q[8*k +: 8];
         if (wr_last_ff.en && wr_last_ff.addr == {{IDX_W{1'b0}}, 2'(k)}) begin
            row_zero[k] = wr_last_ff.data;
         end
         if (!valid_ff[k]) begin
            row_zero[k] = 8'h00;
         end
      end
   end

   always_comb begin
      logic [IDX_W-1:0] idx_v;
      logic [1:0]       off_v;
      logic [CNT_W-1:0] cnt_v;
      phase_type        ph_v;
      logic             zero_v;
      logic [IDX_W:0]   step_v;
      logic [4:0]       base_v;
      logic [7:0]       top_v;
      logic             pulse_v;
      logic [7:0]       rdata_v;

      idx_v   = idx_ff;
      off_v   = off_ff;
      cnt_v   = cnt_ff;
      ph_v    = phase_ff;
      zero_v  = zero_ff;
      step_v  = '0;
      base_v  = '0;
      top_v   = '0;
      pulse_v = 1'b0;
      rdata_v = 8'h00;
      clear_in = clear_ff;
      sec_in   = sec_ff;
      latch_in = latch_ff;
      wr       = '0;

      if (fire) begin
         unique case (item.op)
            OP_WRITE: begin
               wr.en   = 1'b1;
               wr.addr = item.table_addr;
               wr.data = item.write_data;
            end
            OP_READ: begin
               rdata_v = sec_ff[item.table_addr[SEC_ADDR_W-1:0]];
            end
            OP_TICK: begin
               if (item.dot >= DOT_CLEAR_FIRST && item.dot <= DOT_CLEAR_LAST) begin
                  if (item.dot == DOT_CLEAR_FIRST) begin
                     clear_in = 1'b1;
                  end
                  if (item.dot[0]) begin
                     sec_in[item.dot[5:1]] = SEC_FILL;
                  end
               end else if (item.dot >= DOT_EVAL_FIRST && item.dot <= DOT_EVAL_LAST) begin
                  if (item.dot == DOT_EVAL_FIRST) begin
                     clear_in = 1'b0;
                     idx_v    = '0;
                     off_v    = '0;
                     cnt_v    = '0;
                     ph_v     = PH_COPY;
                     zero_v   = 1'b0;
                  end
                  if (item.dot[0]) begin
                     if (item.dot == DOT_EVAL_FIRST) begin
                        latch_in = row_zero;
                     end else begin
                        latch_in = row_cur;
                     end
                  end else begin
                     unique case (ph_v)
                        PH_COPY: begin
                           base_v = {cnt_v[2:0], 2'b00};
                           sec_in[base_v] = latch_ff[0];
                           if (hit(item.line, latch_ff[0], tall)) begin
                              sec_in[base_v | 5'd1] = latch_ff[1];
                              sec_in[base_v | 5'd2] = latch_ff[2];
                              sec_in[base_v | 5'd3] = latch_ff[3];
                              if (idx_v == '0) begin
                                 zero_v = 1'b1;
                              end
                              cnt_v = cnt_v + 1'b1;
                              if (cnt_v >= CNT_W'(SLOTS)) begin
                                 ph_v = PH_OVERFLOW;
                              end
                           end
                           step_v = idx_step(idx_v);
                           idx_v  = step_v[IDX_W-1:0];
                           if (step_v[IDX_W]) begin
                              ph_v = PH_IDLE;
                           end
                        end
                        PH_OVERFLOW: begin
                           top_v   = row_cur[off_v];
                           pulse_v = hit(item.line, top_v, tall);
                           step_v  = idx_step(idx_v);
                           idx_v   = step_v[IDX_W-1:0];
                           if (step_v[IDX_W]) begin
                              ph_v = PH_IDLE;
                           end
                           off_v = off_v + 1'b1;
                        end
                        PH_IDLE: begin
                           step_v = idx_step(idx_v);
                           idx_v  = step_v[IDX_W-1:0];
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            end
            default: begin
            end
         endcase
      end

      idx_in   = idx_v;
      off_in   = off_v;
      cnt_in   = cnt_v;
      phase_in = ph_v;
      zero_in  = zero_v;

      result.overflow_pulse = pulse_v;
      result.zero_in_range  = zero_v;
      result.found_count    = cnt_v;
      result.clear_reads    = clear_in;
      result.read_data      = rdata_v;
   end

   assign rd_row = idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         off_ff     <= '0;
         cnt_ff     <= '0;
         phase_ff   <= PH_COPY;
         zero_ff    <= 1'b0;
         clear_ff   <= 1'b0;
         valid_ff   <= '0;
         wr_last_ff <= '0;
         for (int i = 0; i < SEC_DEPTH; i++) begin
            sec_ff[i] <= 8'h00;
         end
         for (int k = 0; k < 4; k++) begin
            latch_ff[k] <= 8'h00;
         end
      end else begin
         idx_ff     <= idx_in;
         off_ff     <= off_in;
         cnt_ff     <= cnt_in;
         phase_ff   <= phase_in;
         zero_ff    <= zero_in;
         clear_ff   <= clear_in;
         wr_last_ff <= wr;
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         sec_ff   <= sec_in;
         latch_ff <= latch_in;
      end
   end

endmodule

### tb/sprite_eval_monitor.sv
// ----------------------------------------------------------------------------
// sprite_eval_monitor
// Watches the request, response and register ports of the sprite evaluation
// block. Keeps its own copy of the sprite tables and the evaluation state,
// works out the status each accepted request must return, and compares every
// returned status field by field in order. Failures are counted for the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_eval_monitor (
   input  logic                           clock,
   input  logic                           reset,
   sev_req_if                             req_mon,
   sev_rsp_if                             rsp_mon,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [sev_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sev_pkg::CSR_DATA_W-1:0] pwdata,
   output int                             fail_count,
   output int                             pending
);
   import sev_pkg::*;

   logic [7:0]       primary_mem   [256];
   logic [7:0]       secondary_mem [SEC_DEPTH];
   logic [7:0]       sprite_bytes  [4];
   logic [IDX_W-1:0] sprite_idx;
   logic [1:0]       diag_offset;
   logic [CNT_W-1:0] copies;
   phase_type        eval_phase;
   logic             zero_seen;
   logic             clearing;
   logic             tall;
   rsp_item_type     status_queue [$];
   int               errors;

   function automatic bit covers_line(input logic [8:0] ln, input logic [7:0] top);
      int height;
      height = tall ? 16 : 8;
      return int'(ln) >= int'(top) && int'(ln) < int'(top) + height;
   endfunction

   function automatic void step_index();
      if (int'(sprite_idx) + 1 >= SPRITES_DEF) begin
         sprite_idx = '0;
         eval_phase = PH_IDLE;
      end else begin
         sprite_idx = sprite_idx + 1'b1;
      end
   endfunction

   function automatic rsp_item_type predict_status(input req_item_type r);
      rsp_item_type s;
      int           base;
      int           k;
      logic [7:0]   top;
      s = '0;
      case (r.op)
         OP_WRITE: primary_mem[r.table_addr] = r.write_data;
         OP_READ:  s.read_data = secondary_mem[r.table_addr[SEC_ADDR_W-1:0]];
         OP_TICK: begin
            if (r.dot >= DOT_CLEAR_FIRST && r.dot <= DOT_CLEAR_LAST) begin
               if (r.dot == DOT_CLEAR_FIRST)
                  clearing = 1'b1;
               if (r.dot[0])
                  secondary_mem[r.dot[5:1]] = SEC_FILL;
            end else if (r.dot >= DOT_EVAL_FIRST && r.dot <= DOT_EVAL_LAST) begin
               if (r.dot == DOT_EVAL_FIRST) begin
                  clearing    = 1'b0;
                  sprite_idx  = '0;
                  diag_offset = '0;
                  copies      = '0;
                  eval_phase  = PH_COPY;
                  zero_seen   = 1'b0;
               end
               if (r.dot[0]) begin
                  for (k = 0; k < 4; k++)
                     sprite_bytes[k] = primary_mem[8'(int'(sprite_idx) * 4 + k)];
               end else begin
                  case (eval_phase)
                     PH_COPY: begin
                        base = int'(copies) * 4;
                        secondary_mem[5'(base)] = sprite_bytes[0];
                        if (covers_line(r.line, sprite_bytes[0])) begin
                           for (k = 1; k < 4; k++)
                              secondary_mem[5'(base + k)] = sprite_bytes[k];
                           if (sprite_idx == '0)
                              zero_seen = 1'b1;
                           copies = copies + 1'b1;
                           if (int'(copies) >= SLOTS_DEF)
                              eval_phase = PH_OVERFLOW;
                        end
                        step_index();
                     end
                     PH_OVERFLOW: begin
                        top = primary_mem[8'(int'(sprite_idx) * 4 + int'(diag_offset))];
                        s.overflow_pulse = covers_line(r.line, top);
                        step_index();
                        diag_offset = diag_offset + 1'b1;
                     end
                     PH_IDLE: step_index();
                     default: ;
                  endcase
               end
            end
         end
         default: ;
      endcase
      s.zero_in_range = zero_seen;
      s.found_count   = copies;
      s.clear_reads   = clearing;
      return s;
   endfunction

   always @(posedge clock) begin
      req_item_type req;
      rsp_item_type seen;
      rsp_item_type want;
      int           k;
      if (reset) begin
         for (k = 0; k < 256; k++)
            primary_mem[k] = '0;
         for (k = 0; k < SEC_DEPTH; k++)
            secondary_mem[k] = '0;
         for (k = 0; k < 4; k++)
            sprite_bytes[k] = '0;
         sprite_idx  = '0;
         diag_offset = '0;
         copies      = '0;
         eval_phase  = PH_COPY;
         zero_seen   = 1'b0;
         clearing    = 1'b0;
         tall        = 1'b0;
         errors      = 0;
         status_queue.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.overflow_pulse = rsp_mon.overflow_pulse;
            seen.zero_in_range  = rsp_mon.zero_in_range;
            seen.found_count    = rsp_mon.found_count;
            seen.clear_reads    = rsp_mon.clear_reads;
            seen.read_data      = rsp_mon.read_data;
            if (status_queue.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected status ovf=%0d zero=%0d cnt=%0d clr=%0d rd=%02h",
                           $realtime, seen.overflow_pulse, seen.zero_in_range,
                           seen.found_count, seen.clear_reads, seen.read_data);
            end else begin
               want = status_queue.pop_front();
               if (seen.overflow_pulse !== want.overflow_pulse ||
                   seen.zero_in_range  !== want.zero_in_range  ||
                   seen.found_count    !== want.found_count    ||
                   seen.clear_reads    !== want.clear_reads    ||
                   seen.read_data      !== want.read_data) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: status mismatch: expected ovf=%0d zero=%0d cnt=%0d",
                              $realtime, want.overflow_pulse, want.zero_in_range,
                              want.found_count);
                     $display("   expected clr=%0d rd=%02h, got ovf=%0d zero=%0d cnt=%0d",
                              want.clear_reads, want.read_data, seen.overflow_pulse,
                              seen.zero_in_range, seen.found_count);
                     $display("   got clr=%0d rd=%02h", seen.clear_reads, seen.read_data);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            req.op         = req_mon.op;
            req.dot        = req_mon.dot;
            req.line       = req_mon.line;
            req.table_addr = req_mon.table_addr;
            req.write_data = req_mon.write_data;
            status_queue.push_back(predict_status(req));
         end
         if (psel && penable && pwrite && pready && paddr == CSR_TALL_ADDR)
            tall = pwdata[0];
      end
      fail_count <= errors;
      pending    <= status_queue.size();
   end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the sprite evaluation block. Loads the primary
// table, runs short and full scanlines with random content under both sprite
// heights, mixes in malformed sequences and random requests, and stalls both
// channels at random, including one long response hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import sev_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         IDLE_PCT    = 18;
   localparam int         HOLD_CYCLES = 300;
   localparam int         STALL_LIMIT = 4000;
   localparam int         PHASES      = 6;
   localparam int         PHASE_ITEMS = 125;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    fail_count;
   int                    pending;
   int                    sent;
   int                    stall_cycles;
   bit                    calm;
   bit                    hold_request;
   bit                    tall_now;

   sev_req_if req_bus ();
   sev_rsp_if rsp_bus ();

   sprite_evaluation_secondary_copy_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   sprite_eval_monitor status_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("FAIL sprite_evaluation_secondary_copy_top");
      $finish;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   task automatic issue(input logic [1:0] op, input logic [8:0] dot, input logic [8:0] ln,
                        input logic [7:0] addr, input logic [7:0] data);
      req_bus.valid      <= 1'b1;
      req_bus.op         <= op;
      req_bus.dot        <= dot;
      req_bus.line       <= ln;
      req_bus.table_addr <= addr;
      req_bus.write_data <= data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent++;
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic tick(input logic [8:0] dot, input logic [8:0] ln);
      issue(OP_TICK, dot, ln, 8'($urandom_range(255)), 8'($urandom_range(255)));
   endtask

   task automatic write_primary(input logic [7:0] addr, input logic [7:0] data);
      issue(OP_WRITE, 9'($urandom_range(511)), 9'($urandom_range(511)), addr, data);
   endtask

   task automatic read_secondary(input logic [7:0] addr);
      issue(OP_READ, 9'($urandom_range(511)), 9'($urandom_range(511)), addr,
            8'($urandom_range(255)));
   endtask

   // hold until every status is back, then write the sprite height
   task automatic write_height(input bit value);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_TALL_ADDR;
      pwdata  <= ($urandom() & ~32'h1) | CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      tall_now = value;
   endtask

   function automatic logic [7:0] near_top(input int ln, input int span);
      int v;
      v = ln - int'($urandom_range(0, span));
      if (v < 0 || v > 255)
         return 8'($urandom_range(255));
      return 8'(v);
   endfunction

   task automatic run_scanline();
      int ln;
      int pairs;
      int reach;
      int span;
      int crowd;
      int s;
      int b;
      ln    = $urandom_range(261);
      pairs = ($urandom_range(19) == 0) ? $urandom_range(64, 100) : $urandom_range(3, 24);
      reach = (pairs < 63) ? pairs : 63;
      span  = tall_now ? 16 : 8;
      if ($urandom_range(3) == 0) begin
         crowd = $urandom_range(8, 12);
         for (s = 0; s <= crowd; s++)
            write_primary(8'(4 * s), near_top(ln, span));
      end
      repeat ($urandom_range(0, 12)) begin
         s = $urandom_range(0, reach);
         b = ($urandom_range(9) < 6) ? 0 : $urandom_range(1, 3);
         write_primary(8'(4 * s + b), ($urandom_range(99) < 55) ? near_top(ln, span)
                                                                 : 8'($urandom_range(255)));
      end
      tick(DOT_CLEAR_FIRST, 9'(ln));
      repeat ($urandom_range(0, 4)) tick(9'($urandom_range(2, 64)), 9'(ln));
      if ($urandom_range(9) != 0)
         tick(DOT_EVAL_FIRST, 9'(ln));
      repeat (pairs) begin
         tick(9'(66 + 2 * $urandom_range(0, 95)), 9'(ln));
         if ($urandom_range(19) != 0)
            tick(9'(67 + 2 * $urandom_range(0, 94)), 9'(ln));
      end
      repeat ($urandom_range(0, 6)) read_secondary(8'($urandom_range(255)));
   endtask

   task automatic noise_burst();
      repeat ($urandom_range(1, 6))
         issue(2'($urandom_range(3)), 9'($urandom_range(511)), 9'($urandom_range(511)),
               8'($urandom_range(255)), 8'($urandom_range(255)));
   endtask

   initial begin
      int phase_no;
      int target;
      reset              <= 1'b1;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.op         <= OP_TICK;
      req_bus.dot        <= '0;
      req_bus.line       <= '0;
      req_bus.table_addr <= '0;
      req_bus.write_data <= '0;
      calm         = 1'b0;
      hold_request = 1'b0;
      tall_now     = 1'b0;
      sent         = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_height(1'b0);
      write_primary(8'hFF, 8'hFF);
      write_primary(8'h00, 8'h05);
      write_primary(8'h01, 8'h00);
      write_primary(8'h04, 8'h0A);
      write_primary(8'h07, 8'h80);
      issue(OP_UNUSED, 9'h1FF, 9'h1FF, 8'hFF, 8'hFF);
      tick(9'd0, 9'd12);
      tick(9'd257, 9'd12);
      tick(9'h1FF, 9'h1FF);
      tick(DOT_CLEAR_FIRST, 9'd12);
      tick(9'd63, 9'd12);
      tick(DOT_CLEAR_LAST, 9'd12);
      read_secondary(8'hFF);
      read_secondary(8'h00);
      tick(DOT_EVAL_FIRST, 9'd12);
      tick(9'd66, 9'd12);
      tick(9'd67, 9'd12);
      tick(9'd68, 9'd12);
      tick(9'd69, 9'd12);
      tick(DOT_EVAL_LAST, 9'd12);
      read_secondary(8'h07);
      read_secondary(8'hE3);
      tick(9'd340, 9'd261);
      tick(9'd100, 9'd12);

      for (phase_no = 0; phase_no < PHASES; phase_no++) begin
         write_height((phase_no == 0) ? 1'b1 : (phase_no == 1) ? 1'b0 : 1'($urandom_range(1)));
         calm = (phase_no == 2);
         if (phase_no == 3)
            hold_request = 1'b1;
         target = sent + PHASE_ITEMS;
         while (sent < target) begin
            if ($urandom_range(99) < 80)
               run_scanline();
            else
               noise_burst();
         end
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("PASS sprite_evaluation_secondary_copy_top");
      else
         $display("FAIL sprite_evaluation_secondary_copy_top");
      $finish;
   end

endmodule
